// ----- sv/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle stream monitor package
// Sample and counter widths, transaction payload types, register map and
// shared arithmetic helpers.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 32;
  localparam int CFG_ADDR_BITS = 3;

  // Register map
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_LIMIT    = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_HYSTERESIS    = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] REG_EXPECTED_LOW  = CFG_ADDR_BITS'(2);
  localparam logic [CFG_ADDR_BITS-1:0] REG_EXPECTED_HIGH = CFG_ADDR_BITS'(3);
  localparam logic [CFG_ADDR_BITS-1:0] REG_TOLERANCE     = CFG_ADDR_BITS'(4);

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] STEP_LIMIT_RST    = SAMPLE_BITS'(68);
  localparam logic [SAMPLE_BITS-1:0] HYSTERESIS_RST    = SAMPLE_BITS'(96);
  localparam logic [SAMPLE_BITS-1:0] EXPECTED_LOW_RST  = '0;
  localparam logic [SAMPLE_BITS-1:0] EXPECTED_HIGH_RST = '1;
  localparam logic [SAMPLE_BITS-1:0] TOLERANCE_RST     = SAMPLE_BITS'(150);

  typedef enum logic [1:0] {
    SLOPE_UNKNOWN = 2'd0,
    SLOPE_RISING  = 2'd1,
    SLOPE_FALLING = 2'd2
  } slope_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] step_limit;
    logic [SAMPLE_BITS-1:0] hysteresis;
    logic [SAMPLE_BITS-1:0] expected_low;
    logic [SAMPLE_BITS-1:0] expected_high;
    logic [SAMPLE_BITS-1:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   start_of_run;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] run_min;
    logic [SAMPLE_BITS-1:0] run_max;
    logic [COUNT_BITS-1:0]  reversal_count;
    logic [COUNT_BITS-1:0]  jump_count;
    slope_t                 slope;
  } stats_t;

  typedef struct packed {
    logic min_off;
    logic max_off;
    logic flat_signal;
  } flags_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] run_min;
    logic [SAMPLE_BITS-1:0] run_max;
    logic [COUNT_BITS-1:0]  reversal_count;
    logic [COUNT_BITS-1:0]  jump_count;
    logic [1:0]             slope;
    logic                   min_off;
    logic                   max_off;
    logic                   flat_signal;
  } out_item_t;

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b
  );
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

// ----- sv/tsm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Triangle stream monitor configuration registers
// Holds the five threshold registers written over the configuration port.
// ----------------------------------------------------------------------------
module tsm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [tsm_pkg::CFG_ADDR_BITS-1:0]  wr_addr,
  input  logic [tsm_pkg::SAMPLE_BITS-1:0]    wr_data,
  output tsm_pkg::cfg_t                      cfg
);
  import tsm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_addr)
        REG_STEP_LIMIT:    cfg_nxt.step_limit    = wr_data;
        REG_HYSTERESIS:    cfg_nxt.hysteresis    = wr_data;
        REG_EXPECTED_LOW:  cfg_nxt.expected_low  = wr_data;
        REG_EXPECTED_HIGH: cfg_nxt.expected_high = wr_data;
        REG_TOLERANCE:     cfg_nxt.tolerance     = wr_data;
        default:           cfg_nxt = cfg_r;  // drop writes outside the map
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_limit    <= STEP_LIMIT_RST;
      cfg_r.hysteresis    <= HYSTERESIS_RST;
      cfg_r.expected_low  <= EXPECTED_LOW_RST;
      cfg_r.expected_high <= EXPECTED_HIGH_RST;
      cfg_r.tolerance     <= TOLERANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/tsm_track.sv -----
// ----------------------------------------------------------------------------
// Triangle stream monitor run tracker
// Running min/max, previous sample, jump counter and hysteretic slope
// reversal detector. Returns the statistics after the current sample.
// ----------------------------------------------------------------------------
module tsm_track (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  tsm_pkg::in_item_t      item,
  input  tsm_pkg::cfg_t          cfg,
  output tsm_pkg::stats_t        stats
);
  import tsm_pkg::*;

  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SAMPLE_BITS-1:0] ext_r, ext_nxt;
  slope_t                 dir_r, dir_nxt;
  logic                   first_r, first_nxt;
  logic [COUNT_BITS-1:0]  rev_r, rev_nxt;
  logic [COUNT_BITS-1:0]  jump_r, jump_nxt;

  // state as seen by this sample, after an optional run clear
  logic [SAMPLE_BITS-1:0] cur_min, cur_max, cur_prev, cur_ext;
  slope_t                 cur_dir;
  logic                   cur_first;
  logic [COUNT_BITS-1:0]  cur_rev, cur_jump;
  logic [SAMPLE_BITS-1:0] v;
  logic [SAMPLE_BITS:0]   ext_plus_hys, v_plus_hys;

  always_comb begin
    v         = item.sample;
    cur_min   = item.start_of_run ? '1 : min_r;
    cur_max   = item.start_of_run ? '0 : max_r;
    cur_prev  = item.start_of_run ? '0 : prev_r;
    cur_ext   = item.start_of_run ? '0 : ext_r;
    cur_dir   = item.start_of_run ? SLOPE_UNKNOWN : dir_r;
    cur_first = item.start_of_run | first_r;
    cur_rev   = item.start_of_run ? '0 : rev_r;
    cur_jump  = item.start_of_run ? '0 : jump_r;

    ext_plus_hys = {1'b0, cur_ext} + {1'b0, cfg.hysteresis};
    v_plus_hys   = {1'b0, v} + {1'b0, cfg.hysteresis};

    min_nxt   = (v < cur_min) ? v : cur_min;
    max_nxt   = (v > cur_max) ? v : cur_max;
    prev_nxt  = v;
    ext_nxt   = cur_ext;
    dir_nxt   = cur_dir;
    first_nxt = 1'b0;
    rev_nxt   = cur_rev;
    jump_nxt  = cur_jump;

    if (cur_first) begin
      ext_nxt = v;
    end else begin
      if (abs_diff(v, cur_prev) > cfg.step_limit) begin
        jump_nxt = sat_inc(cur_jump);
      end
      case (cur_dir)
        SLOPE_RISING: begin
          if (v > cur_ext) begin
            ext_nxt = v;
          end else if (cur_ext - v > cfg.hysteresis) begin
            rev_nxt = sat_inc(cur_rev);
            dir_nxt = SLOPE_FALLING;
            ext_nxt = v;
          end
        end
        SLOPE_FALLING: begin
          if (v < cur_ext) begin
            ext_nxt = v;
          end else if (v - cur_ext > cfg.hysteresis) begin
            rev_nxt = sat_inc(cur_rev);
            dir_nxt = SLOPE_RISING;
            ext_nxt = v;
          end
        end
        default: begin
          if ({1'b0, v} > ext_plus_hys) begin
            dir_nxt = SLOPE_RISING;
            ext_nxt = v;
          end else if (v_plus_hys < {1'b0, cur_ext}) begin
            dir_nxt = SLOPE_FALLING;
            ext_nxt = v;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= '1;
      max_r   <= '0;
      prev_r  <= '0;
      ext_r   <= '0;
      dir_r   <= SLOPE_UNKNOWN;
      first_r <= 1'b1;
      rev_r   <= '0;
      jump_r  <= '0;
    end else if (step) begin
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      prev_r  <= prev_nxt;
      ext_r   <= ext_nxt;
      dir_r   <= dir_nxt;
      first_r <= first_nxt;
      rev_r   <= rev_nxt;
      jump_r  <= jump_nxt;
    end
  end

  assign stats.run_min        = min_nxt;
  assign stats.run_max        = max_nxt;
  assign stats.reversal_count = rev_nxt;
  assign stats.jump_count     = jump_nxt;
  assign stats.slope          = dir_nxt;

endmodule

// ----- sv/tsm_flags.sv -----
// ----------------------------------------------------------------------------
// Triangle stream monitor window checks
// Flags extremes outside the tolerance window and a flat signal.
// ----------------------------------------------------------------------------
module tsm_flags (
  input  tsm_pkg::stats_t  stats,
  input  tsm_pkg::cfg_t    cfg,
  output tsm_pkg::flags_t  flags
);
  import tsm_pkg::*;

  logic [SAMPLE_BITS:0] min_plus_hys;

  assign min_plus_hys = {1'b0, stats.run_min} + {1'b0, cfg.hysteresis};

  assign flags.min_off     = abs_diff(stats.run_min, cfg.expected_low) > cfg.tolerance;
  assign flags.max_off     = abs_diff(stats.run_max, cfg.expected_high) > cfg.tolerance;
  assign flags.flat_signal = {1'b0, stats.run_max} < min_plus_hys;

endmodule

// ----- sv/triangle_stream_monitor_core.sv -----
// ----------------------------------------------------------------------------
// Triangle stream monitor
// Running statistics, jump counter and hysteretic slope reversal counter
// for a stream of converter samples, one result per sample.
// ----------------------------------------------------------------------------
// The block returns one result per sample. An accepted sample is held in the
// input register; its result is computed from that register and loads into
// the result register, from which it is presented. The tracker state closes
// its loop through combinational logic around its registers, so the sustained
// rate is one sample per cycle whenever the result side is not stalling. Write
// configuration only while no samples are in flight; cfg_ready is always high.
module triangle_stream_monitor_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tsm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tsm_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [tsm_pkg::SAMPLE_BITS-1:0]   cfg_wdata
);
  import tsm_pkg::*;

  cfg_t      cfg;
  stats_t    stats;
  flags_t    flags;
  in_item_t  s1_data_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      s2_load, s1_load, step;

  assign cfg_ready = 1'b1;

  tsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_wdata),
    .cfg     (cfg)
  );

  // result register can take a new transaction when empty or draining
  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;
  assign step     = s1_valid_r && s2_load;

  tsm_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_data_r),
    .cfg   (cfg),
    .stats (stats)
  );

  tsm_flags u_flags (
    .stats (stats),
    .cfg   (cfg),
    .flags (flags)
  );

  always_comb begin
    out_data_nxt.run_min        = stats.run_min;
    out_data_nxt.run_max        = stats.run_max;
    out_data_nxt.reversal_count = stats.reversal_count;
    out_data_nxt.jump_count     = stats.jump_count;
    out_data_nxt.slope          = stats.slope;
    out_data_nxt.min_off        = flags.min_off;
    out_data_nxt.max_off        = flags.max_off;
    out_data_nxt.flat_signal    = flags.flat_signal;
    s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
    out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every result has seen at least one sample, so min never exceeds max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.run_min <= out_data_r.run_max)
    else $error("run_min above run_max");

  // a run start clears both counters before the sample is counted
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && s1_data_r.start_of_run |=>
      out_data_r.reversal_count == '0 && out_data_r.jump_count == '0)
    else $error("counters not cleared at run start");

  // input side only holds off when the input register is occupied
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with free pipeline");

endmodule

// ----- tb/triangle_stream_monitor_core_tb.sv -----
// ----------------------------------------------------------------------------
// Triangle stream monitor testbench
// Streams directed and random sample sequences (mostly noisy triangle ramps)
// through the core under random idle and stall gaps. Each result is checked
// field by field against a scoreboard fed by an in-bench tracker. Registers
// are rewritten between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module triangle_stream_monitor_core_tb;
  import tsm_pkg::*;

  localparam int DRAIN_LIMIT = 4000;
  localparam int ITEM_TARGET = 1150;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [SAMPLE_BITS-1:0]   cfg_wdata = '0;

  triangle_stream_monitor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Tracker state and register shadow
  cfg_t                   reg_shadow;
  logic [SAMPLE_BITS-1:0] trk_min;
  logic [SAMPLE_BITS-1:0] trk_max;
  logic [SAMPLE_BITS-1:0] trk_prev;
  logic [SAMPLE_BITS-1:0] trk_extreme;
  slope_t                 trk_dir;
  logic                   trk_first;
  logic [COUNT_BITS-1:0]  trk_reversals;
  logic [COUNT_BITS-1:0]  trk_jumps;

  in_item_t  sample_queue[$];
  out_item_t expected_stats[$];
  int        items_queued = 0;
  int        results_seen = 0;
  int        error_count = 0;
  int        send_gap = 0;
  int        send_calm = 0;
  int        stall_left = 0;
  int        recv_calm = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  function automatic int idle_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int abs_dist(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic void clear_tracker();
    trk_min       = '1;
    trk_max       = '0;
    trk_prev      = '0;
    trk_extreme   = '0;
    trk_dir       = SLOPE_UNKNOWN;
    trk_first     = 1'b1;
    trk_reversals = '0;
    trk_jumps     = '0;
  endfunction

  function automatic out_item_t predict_stats(input in_item_t item);
    out_item_t r;
    int        v;
    int        ext;
    int        hyst;
    v = int'(item.sample);
    if (item.start_of_run) clear_tracker();
    if (v < int'(trk_min)) trk_min = item.sample;
    if (v > int'(trk_max)) trk_max = item.sample;
    hyst = int'(reg_shadow.hysteresis);
    ext  = int'(trk_extreme);
    if (trk_first) begin
      // first sample of a run only seeds the tracker
      trk_first   = 1'b0;
      trk_extreme = item.sample;
      trk_prev    = item.sample;
    end else begin
      if (abs_dist(v, int'(trk_prev)) > int'(reg_shadow.step_limit)) begin
        trk_jumps = bump(trk_jumps);
      end
      trk_prev = item.sample;
      case (trk_dir)
        SLOPE_RISING: begin
          if (v > ext) begin
            trk_extreme = item.sample;
          end else if (ext - v > hyst) begin
            trk_reversals = bump(trk_reversals);
            trk_dir       = SLOPE_FALLING;
            trk_extreme   = item.sample;
          end
        end
        SLOPE_FALLING: begin
          if (v < ext) begin
            trk_extreme = item.sample;
          end else if (v - ext > hyst) begin
            trk_reversals = bump(trk_reversals);
            trk_dir       = SLOPE_RISING;
            trk_extreme   = item.sample;
          end
        end
        default: begin
          // settle the initial direction without counting a turn
          if (v > ext + hyst) begin
            trk_dir     = SLOPE_RISING;
            trk_extreme = item.sample;
          end else if (v + hyst < ext) begin
            trk_dir     = SLOPE_FALLING;
            trk_extreme = item.sample;
          end
        end
      endcase
    end
    r.run_min        = trk_min;
    r.run_max        = trk_max;
    r.reversal_count = trk_reversals;
    r.jump_count     = trk_jumps;
    r.slope          = trk_dir;
    r.min_off        = abs_dist(int'(trk_min), int'(reg_shadow.expected_low)) >
                       int'(reg_shadow.tolerance);
    r.max_off        = abs_dist(int'(trk_max), int'(reg_shadow.expected_high)) >
                       int'(reg_shadow.tolerance);
    r.flat_signal    = int'(trk_max) < int'(trk_min) + hyst;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [COUNT_BITS-1:0] got,
                             input logic [COUNT_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_stats.size() == 0) begin
      report_mismatch("result with no pending expectation");
      return;
    end
    want = expected_stats.pop_front();
    check_field("run_min", COUNT_BITS'(got.run_min), COUNT_BITS'(want.run_min));
    check_field("run_max", COUNT_BITS'(got.run_max), COUNT_BITS'(want.run_max));
    check_field("reversal_count", got.reversal_count, want.reversal_count);
    check_field("jump_count", got.jump_count, want.jump_count);
    check_field("slope", COUNT_BITS'(got.slope), COUNT_BITS'(want.slope));
    check_field("min_off", COUNT_BITS'(got.min_off), COUNT_BITS'(want.min_off));
    check_field("max_off", COUNT_BITS'(got.max_off), COUNT_BITS'(want.max_off));
    check_field("flat_signal", COUNT_BITS'(got.flat_signal),
                COUNT_BITS'(want.flat_signal));
  endtask

  // Driver: predict on each accepted transaction, then load the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_stats.push_back(predict_stats(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_data  <= sample_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted results and generate back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result(out_data);
      results_seen++;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_gap(recv_calm);
    end
  end

  task automatic push_item(input int value, input bit start);
    in_item_t it;
    it.sample       = value[SAMPLE_BITS-1:0];
    it.start_of_run = start;
    sample_queue.push_back(it);
    items_queued++;
  endtask

  task automatic push_triangle(input int n);
    int lo, hi, step, noise, v, up;
    lo    = $urandom_range(0, 3000);
    hi    = $urandom_range(lo, 4095);
    step  = $urandom_range(1, 300);
    noise = $urandom_range(0, 40);
    v     = $urandom_range(lo, hi);
    up    = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      push_item(v, (i == 0) && ($urandom_range(0, 2) == 0));
      v = up ? v + step : v - step;
      v = v + int'($urandom_range(0, 2 * noise)) - noise;
      // bounce off the ramp limits
      if (v >= hi) begin
        v  = hi;
        up = 0;
      end else if (v <= lo) begin
        v  = lo;
        up = 1;
      end
    end
  endtask

  task automatic fill_phase(input int n);
    int target;
    target = items_queued + n;
    if (target > ITEM_TARGET) target = ITEM_TARGET;
    while (items_queued < target) begin
      if ($urandom_range(0, 99) < 80) begin
        push_triangle($urandom_range(8, 60));
      end else begin
        repeat ($urandom_range(1, 10)) begin
          push_item($urandom_range(0, 4095), $urandom_range(0, 11) == 0);
        end
      end
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    do @(negedge clk); while (sample_queue.size() != 0 || in_valid);
    while (expected_stats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input int value);
    logic [SAMPLE_BITS-1:0] v;
    v = value[SAMPLE_BITS-1:0];
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP_LIMIT:    reg_shadow.step_limit    = v;
      REG_HYSTERESIS:    reg_shadow.hysteresis    = v;
      REG_EXPECTED_LOW:  reg_shadow.expected_low  = v;
      REG_EXPECTED_HIGH: reg_shadow.expected_high = v;
      REG_TOLERANCE:     reg_shadow.tolerance     = v;
      default: ;
    endcase
  endtask

  task automatic write_config(input int jl, input int hy, input int lo, input int hi,
                              input int tol);
    write_reg(REG_STEP_LIMIT, jl);
    write_reg(REG_HYSTERESIS, hy);
    write_reg(REG_EXPECTED_LOW, lo);
    write_reg(REG_EXPECTED_HIGH, hi);
    write_reg(REG_TOLERANCE, tol);
    @(negedge clk);
  endtask

  function automatic int pick_reg_value(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 24) return (1 << SAMPLE_BITS) - 1;
    return $urandom_range(lo, hi);
  endfunction

  initial begin
    int phase;
    reg_shadow.step_limit    = STEP_LIMIT_RST;
    reg_shadow.hysteresis    = HYSTERESIS_RST;
    reg_shadow.expected_low  = EXPECTED_LOW_RST;
    reg_shadow.expected_high = EXPECTED_HIGH_RST;
    reg_shadow.tolerance     = TOLERANCE_RST;
    clear_tracker();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: hysteresis and jump limit edges, turns both ways
    push_item(2048, 1);
    push_item(2144, 0);
    push_item(2145, 0);
    push_item(2200, 0);
    push_item(2104, 0);
    push_item(2103, 0);
    push_item(2050, 0);
    push_item(2146, 0);
    push_item(2147, 0);
    push_item(2215, 0);
    push_item(2284, 0);
    push_item(0, 0);
    push_item(4095, 0);
    push_item(4095, 1);
    push_item(0, 0);
    push_item(0, 1);
    push_item(0, 0);
    push_item(1, 0);
    wait_drained();

    // Zero thresholds: every change is a jump and a move
    write_config(0, 0, 0, 4095, 0);
    push_item(100, 1);
    push_item(100, 0);
    push_item(101, 0);
    push_item(100, 0);
    push_item(0, 0);
    push_item(4095, 0);
    wait_drained();

    // Full-scale thresholds with inverted nominal window
    write_config(4095, 4095, 4095, 0, 4095);
    push_item(0, 1);
    push_item(4095, 0);
    push_item(0, 0);
    push_item(2000, 0);
    wait_drained();

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      write_config(pick_reg_value(0, 200), pick_reg_value(0, 300),
                   pick_reg_value(0, 500), pick_reg_value(3500, 4095),
                   pick_reg_value(0, 400));
      if (phase % 2 == 1) begin
        // hold the sender until the scoreboard empties mid-phase
        fill_phase(100);
        wait_drained();
        fill_phase(100);
      end else begin
        fill_phase($urandom_range(150, 250));
      end
      wait_drained();
      phase++;
    end

    if (expected_stats.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_stats.size()));
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
